[src/msgd_pkg.sv]
package msgd_pkg;

   localparam logic [2:0] KIND_TRAIN  = 3'd0;
   localparam logic [2:0] KIND_COMMIT = 3'd1;
   localparam logic [2:0] KIND_WRITE  = 3'd2;
   localparam logic [2:0] KIND_READ   = 3'd3;
   localparam logic [2:0] KIND_CLEAR  = 3'd4;

   localparam logic [1:0] CSR_LEARNING_RATE = 2'd0;
   localparam logic [1:0] CSR_MARGIN        = 2'd1;
   localparam logic [1:0] CSR_DISTANCE_MODE = 2'd2;

   localparam logic [15:0] LR_RESET     = 16'd6554;
   localparam logic [15:0] MARGIN_RESET = 16'd4096;

   // gradient magnitude in L1 mode, 1.0 in Q.12
   localparam int GRAD_ONE = 4096;

   localparam int REQ_WIDTH = 80;
   localparam int RSP_WIDTH = 104;

   typedef struct packed {
      logic [15:0] write_value;
      logic [5:0]  dim_index;
      logic [11:0] element_index;
      logic        table_select;
      logic        corrupt_head;
      logic [11:0] corrupt_entity;
      logic [7:0]  relation;
      logic [11:0] tail;
      logic [11:0] head;
   } item_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIST_RD_T,
      ST_DIST_RD_H,
      ST_DIST_RD_J,
      ST_DIST_POS,
      ST_DIST_NEG,
      ST_DIST_ACC,
      ST_DIST_END,
      ST_GRAD_SP,
      ST_GRAD_SN,
      ST_GRAD_SNR,
      ST_RMW_RD,
      ST_RMW_WR,
      ST_NS_RD,
      ST_NS_MUL,
      ST_NS_ACC,
      ST_NS_CHK,
      ST_SQRT,
      ST_ND_RD,
      ST_ND_LD,
      ST_ND_DIV,
      ST_ND_WR,
      ST_COMMIT,
      ST_EL_WRITE,
      ST_EL_READ,
      ST_EL_CAP,
      ST_DONE
   } state_type;

endpackage

[src/margin_embedding_sgd_step.sv]
// Train item: both distances, then the gradient updates when the margin is violated,
// then per touched vector a norm check, plus when over unit length a square root and
// the 16-step divider, then the output register.
// Commit: one table entry a cycle.
// One item at a time, set by the shared multiplier and the single read port of each
// table. Synchronous reset clears control, registers and total.
module margin_embedding_sgd_step
   import msgd_pkg::*;
#(
   parameter int NUM_ENTITIES  = 4096,
   parameter int NUM_RELATIONS = 256,
   parameter int DIM           = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // head, tail, relation, corrupt_entity, corrupt_head, table_select,
   // element_index, dim_index, write_value
   input  logic [REQ_WIDTH-1:0] req_tdata,
   // kind
   input  logic [2:0]           req_tuser,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // hinge_loss, update_applied, read_value, total_loss, zero fill
   output logic [RSP_WIDTH-1:0] rsp_tdata,
   input  logic                 csr_write_enable,
   input  logic [1:0]           csr_index,
   input  logic [15:0]          csr_write_data
);

   localparam int EDEPTH = NUM_ENTITIES * DIM;
   localparam int RDEPTH = NUM_RELATIONS * DIM;
   localparam int EAW    = (EDEPTH > 1) ? $clog2(EDEPTH) : 1;
   localparam int RAW    = (RDEPTH > 1) ? $clog2(RDEPTH) : 1;
   localparam int CDEPTH = (EDEPTH > RDEPTH) ? EDEPTH : RDEPTH;
   localparam int CW     = $clog2(CDEPTH + 1);
   localparam int IW     = (DIM > 1) ? $clog2(DIM) : 1;
   localparam int AW     = 35 + $clog2(DIM);
   localparam int SW     = 31 + $clog2(DIM);
   localparam int LW     = (SW + 1) / 2 + 1;
   localparam int SQ_EXP = 2 * ((SW - 1) / 2);

   function automatic logic [EAW-1:0] ent_addr(input logic [11:0] idx, input logic [31:0] d);
      logic [31:0] a;
      a = 32'(idx) * 32'(DIM) + d;
      return a[EAW-1:0];
   endfunction

   function automatic logic [RAW-1:0] rel_addr(input logic [11:0] idx, input logic [31:0] d);
      logic [31:0] a;
      a = 32'(idx) * 32'(DIM) + d;
      return a[RAW-1:0];
   endfunction

   function automatic logic signed [19:0] round_step(input logic signed [37:0] p);
      logic [37:0] mag;
      logic [37:0] q;
      mag = p[37] ? 38'(-p) : 38'(p);
      q   = (mag + 38'd32768) >> 16;
      return p[37] ? -20'(q) : 20'(q);
   endfunction

   function automatic logic [15:0] sat16(input logic signed [20:0] v);
      logic [15:0] r;
      if (v > 21'sd32767) begin
         r = 16'h7FFF;
      end else if (v < -21'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   state_type state_ff, state_in;
   item_type  item_ff, item_in, req_item;
   logic [2:0] kind_ff, kind_in;

   logic [15:0] lr_ff, lr_in, margin_ff, margin_in;
   logic        mode_ff, mode_in;

   logic              pass_ff, pass_in;
   logic [IW-1:0]     i_ff, i_in;
   logic [2:0]        u_ff, u_in;
   logic [1:0]        v_ff, v_in;
   logic signed [15:0] t_ff, t_in, h_ff, h_in, j_ff, j_in, r_ff, r_in;
   logic signed [37:0] prod_ff, prod_in;
   logic [AW-1:0]     accp_ff, accp_in, accn_ff, accn_in;
   logic signed [19:0] sp_ff, sp_in, sn_ff, sn_in;
   logic [SW-1:0]     ss_ff, ss_in;
   logic [SW-1:0]     sq_rem_ff, sq_rem_in, sq_res_ff, sq_res_in, sq_bit_ff, sq_bit_in;
   logic [LW-1:0]     len_ff, len_in;
   logic              neg_ff, neg_in;
   logic [LW-1:0]     div_rem_ff, div_rem_in;
   logic [15:0]       div_lo_ff, div_lo_in;
   logic [3:0]        dc_ff, dc_in;
   logic [CW-1:0]     cm_cnt_ff, cm_cnt_in, cm_prev_ff, cm_prev_in;
   logic              cm_we_e_ff, cm_we_e_in, cm_we_r_ff, cm_we_r_in;
   logic [47:0]       total_ff, total_in;
   logic [31:0]       hinge_ff, hinge_in;
   logic              applied_ff, applied_in;
   logic [15:0]       readv_ff, readv_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_WIDTH-1:0] rsp_data_ff, rsp_data_in;

   logic           ec_we, ew_we, rc_we, rw_we;
   logic [EAW-1:0] ec_waddr, ec_raddr, ew_waddr, ew_raddr;
   logic [RAW-1:0] rc_waddr, rc_raddr, rw_waddr, rw_raddr;
   logic [15:0]    ec_wdata, ew_wdata, rc_wdata, rw_wdata;
   logic [15:0]    ec_rdata, ew_rdata, rc_rdata, rw_rdata;

   logic signed [18:0] mult_a, mult_b;
   logic signed [37:0] mult_p;
   logic [37:0]        prod_u;

   logic               i_last, train_ok, el_ok, rmw_rel, vec_rel, viol, sq_ge, div_ge;
   logic [11:0]        nh_idx, nt_idx, rmw_idx, vec_idx;
   logic signed [17:0] dp_w, dn_w;
   logic [17:0]        dp_abs, dn_abs;
   logic signed [18:0] xp_w, xn_w;
   logic [AW-1:0]      dpos_w, dneg_w;
   logic [AW:0]        hinge_full;
   logic [48:0]        total_sum;
   logic signed [19:0] rmw_delta;
   logic [15:0]        rmw_old, vec_old, nd_val, v_mag;
   logic [SW-1:0]      sq_rpb;
   logic [LW:0]        div_trial;
   logic [28:0]        nd_num;

   assign req_item   = item_type'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign i_last   = (i_ff == IW'(DIM - 1));
   assign train_ok = (32'(req_item.head) < 32'(NUM_ENTITIES))
                  && (32'(req_item.tail) < 32'(NUM_ENTITIES))
                  && (32'(req_item.corrupt_entity) < 32'(NUM_ENTITIES))
                  && (32'(req_item.relation) < 32'(NUM_RELATIONS));
   assign el_ok = (item_ff.table_select ? (32'(item_ff.element_index) < 32'(NUM_RELATIONS))
                                        : (32'(item_ff.element_index) < 32'(NUM_ENTITIES)))
               && (32'(item_ff.dim_index) < 32'(DIM));

   assign nh_idx = item_ff.corrupt_head ? item_ff.corrupt_entity : item_ff.head;
   assign nt_idx = item_ff.corrupt_head ? item_ff.tail : item_ff.corrupt_entity;

   assign dp_w = {{2{t_ff[15]}}, t_ff} - {{2{h_ff[15]}}, h_ff} - {{2{r_ff[15]}}, r_ff};
   assign dn_w = (item_ff.corrupt_head ? {{2{t_ff[15]}}, t_ff} : {{2{j_ff[15]}}, j_ff})
               - (item_ff.corrupt_head ? {{2{j_ff[15]}}, j_ff} : {{2{h_ff[15]}}, h_ff})
               - {{2{r_ff[15]}}, r_ff};
   assign dp_abs = dp_w[17] ? 18'(-dp_w) : 18'(dp_w);
   assign dn_abs = dn_w[17] ? 18'(-dn_w) : 18'(dn_w);
   assign xp_w = mode_ff ? ((!dp_w[17] && dp_w != 18'sd0) ? 19'sd4096 : -19'sd4096)
                         : {dp_w, 1'b0};
   assign xn_w = mode_ff ? ((!dn_w[17] && dn_w != 18'sd0) ? 19'(GRAD_ONE) : -19'(GRAD_ONE))
                         : {dn_w, 1'b0};

   assign dpos_w     = mode_ff ? accp_ff : (accp_ff >> 12);
   assign dneg_w     = mode_ff ? accn_ff : (accn_ff >> 12);
   assign viol       = ((AW+1)'(dpos_w) + (AW+1)'(margin_ff)) > (AW+1)'(dneg_w);
   assign hinge_full = (AW+1)'(dpos_w) + (AW+1)'(margin_ff) - (AW+1)'(dneg_w);
   assign total_sum  = {1'b0, total_ff}
                     + ((|hinge_full[AW:32]) ? 49'hFFFF_FFFF : 49'(hinge_full[31:0]));

   assign rmw_rel = (u_ff == 3'd0) || (u_ff == 3'd3);
   always_comb begin
      unique case (u_ff)
         3'd1:    rmw_idx = item_ff.head;
         3'd2:    rmw_idx = item_ff.tail;
         3'd4:    rmw_idx = nh_idx;
         default: rmw_idx = nt_idx;
      endcase
      unique case (u_ff)
         3'd0, 3'd1: rmw_delta = sp_ff;
         3'd2:       rmw_delta = -sp_ff;
         3'd3, 3'd4: rmw_delta = -sn_ff;
         default:    rmw_delta = sn_ff;
      endcase
      unique case (v_ff)
         2'd1:    vec_idx = item_ff.head;
         2'd2:    vec_idx = item_ff.tail;
         default: vec_idx = item_ff.corrupt_entity;
      endcase
   end
   assign vec_rel = (v_ff == 2'd0);
   assign rmw_old = rmw_rel ? rw_rdata : ew_rdata;
   assign vec_old = vec_rel ? rw_rdata : ew_rdata;

   assign mult_p = mult_a * mult_b;
   assign prod_u = prod_ff;

   assign sq_rpb = sq_res_ff + sq_bit_ff;
   assign sq_ge  = (sq_rem_ff >= sq_rpb);

   assign v_mag     = vec_old[15] ? 16'(-vec_old) : vec_old;
   assign nd_num    = 29'({v_mag, 12'b0}) + 29'(len_ff >> 1);
   assign div_trial = {div_rem_ff, div_lo_ff[15]};
   assign div_ge    = (div_trial >= {1'b0, len_ff});

   always_comb begin
      if (!neg_ff) begin
         nd_val = (div_lo_ff > 16'd32767) ? 16'h7FFF : div_lo_ff;
      end else begin
         nd_val = (div_lo_ff > 16'd32768) ? 16'h8000 : 16'(-div_lo_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               priority if (req_tuser == KIND_TRAIN) begin
                  state_in = train_ok ? ST_DIST_RD_T : ST_DONE;
               end else if (req_tuser == KIND_COMMIT) begin
                  state_in = ST_COMMIT;
               end else if (req_tuser == KIND_WRITE) begin
                  state_in = ST_EL_WRITE;
               end else if (req_tuser == KIND_READ) begin
                  state_in = ST_EL_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIST_RD_T: state_in = ST_DIST_RD_H;
         ST_DIST_RD_H: state_in = ST_DIST_RD_J;
         ST_DIST_RD_J: state_in = pass_ff ? ST_GRAD_SP : ST_DIST_POS;
         ST_DIST_POS:  state_in = ST_DIST_NEG;
         ST_DIST_NEG:  state_in = ST_DIST_ACC;
         ST_DIST_ACC:  state_in = i_last ? ST_DIST_END : ST_DIST_RD_T;
         ST_DIST_END:  state_in = viol ? ST_DIST_RD_T : ST_NS_RD;
         ST_GRAD_SP:   state_in = ST_GRAD_SN;
         ST_GRAD_SN:   state_in = ST_GRAD_SNR;
         ST_GRAD_SNR:  state_in = ST_RMW_RD;
         ST_RMW_RD:    state_in = ST_RMW_WR;
         ST_RMW_WR: begin
            if (u_ff != 3'd5) begin
               state_in = ST_RMW_RD;
            end else begin
               state_in = i_last ? ST_NS_RD : ST_DIST_RD_T;
            end
         end
         ST_NS_RD:  state_in = ST_NS_MUL;
         ST_NS_MUL: state_in = ST_NS_ACC;
         ST_NS_ACC: state_in = i_last ? ST_NS_CHK : ST_NS_RD;
         ST_NS_CHK: begin
            if (ss_ff > SW'(32'h0100_0000)) begin
               state_in = ST_SQRT;
            end else begin
               state_in = (v_ff == 2'd3) ? ST_DONE : ST_NS_RD;
            end
         end
         ST_SQRT:   state_in = ((sq_bit_ff >> 2) == '0) ? ST_ND_RD : ST_SQRT;
         ST_ND_RD:  state_in = ST_ND_LD;
         ST_ND_LD:  state_in = ST_ND_DIV;
         ST_ND_DIV: state_in = (dc_ff == 4'd15) ? ST_ND_WR : ST_ND_DIV;
         ST_ND_WR: begin
            if (!i_last) begin
               state_in = ST_ND_RD;
            end else begin
               state_in = (v_ff == 2'd3) ? ST_DONE : ST_NS_RD;
            end
         end
         ST_COMMIT:   state_in = (cm_cnt_ff == CW'(CDEPTH)) ? ST_DONE : ST_COMMIT;
         ST_EL_WRITE: state_in = ST_DONE;
         ST_EL_READ:  state_in = ST_EL_CAP;
         ST_EL_CAP:   state_in = ST_DONE;
         ST_DONE:     state_in = (!rsp_valid_ff || rsp_tready) ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // table ports and multiplier operands
   always_comb begin
      ec_we = 1'b0; ew_we = 1'b0; rc_we = 1'b0; rw_we = 1'b0;
      ec_raddr = ent_addr(item_ff.tail, 32'(i_ff));
      rc_raddr = rel_addr({4'b0, item_ff.relation}, 32'(i_ff));
      ew_raddr = ent_addr(vec_idx, 32'(i_ff));
      rw_raddr = rel_addr({4'b0, item_ff.relation}, 32'(i_ff));
      ec_waddr = ent_addr(item_ff.element_index, 32'(item_ff.dim_index));
      rc_waddr = rel_addr(item_ff.element_index, 32'(item_ff.dim_index));
      ew_waddr = ec_waddr;
      rw_waddr = rc_waddr;
      ec_wdata = item_ff.write_value;
      rc_wdata = item_ff.write_value;
      ew_wdata = item_ff.write_value;
      rw_wdata = item_ff.write_value;
      mult_a = {3'b000, lr_ff};
      mult_b = xp_w;
      unique case (state_ff)
         ST_DIST_RD_H: ec_raddr = ent_addr(item_ff.head, 32'(i_ff));
         ST_DIST_RD_J: ec_raddr = ent_addr(item_ff.corrupt_entity, 32'(i_ff));
         ST_DIST_POS: begin
            mult_a = {dp_w[17], dp_w};
            mult_b = {dp_w[17], dp_w};
         end
         ST_DIST_NEG: begin
            mult_a = {dn_w[17], dn_w};
            mult_b = {dn_w[17], dn_w};
         end
         ST_GRAD_SN: mult_b = xn_w;
         ST_RMW_RD: ew_raddr = ent_addr(rmw_idx, 32'(i_ff));
         ST_RMW_WR: begin
            ew_waddr = ent_addr(rmw_idx, 32'(i_ff));
            rw_waddr = rel_addr({4'b0, item_ff.relation}, 32'(i_ff));
            ew_wdata = sat16({{5{rmw_old[15]}}, rmw_old} + {rmw_delta[19], rmw_delta});
            rw_wdata = ew_wdata;
            ew_we    = !rmw_rel;
            rw_we    = rmw_rel;
         end
         ST_NS_MUL: begin
            mult_a = {{3{vec_old[15]}}, vec_old};
            mult_b = {{3{vec_old[15]}}, vec_old};
         end
         ST_ND_WR: begin
            ew_waddr = ent_addr(vec_idx, 32'(i_ff));
            rw_waddr = rel_addr({4'b0, item_ff.relation}, 32'(i_ff));
            ew_wdata = nd_val;
            rw_wdata = nd_val;
            ew_we    = !vec_rel;
            rw_we    = vec_rel;
         end
         ST_COMMIT: begin
            ew_raddr = cm_cnt_ff[EAW-1:0];
            rw_raddr = cm_cnt_ff[RAW-1:0];
            ec_waddr = cm_prev_ff[EAW-1:0];
            rc_waddr = cm_prev_ff[RAW-1:0];
            ec_wdata = ew_rdata;
            rc_wdata = rw_rdata;
            ec_we    = cm_we_e_ff;
            rc_we    = cm_we_r_ff;
         end
         ST_EL_WRITE: begin
            ec_we = el_ok && !item_ff.table_select;
            ew_we = el_ok && !item_ff.table_select;
            rc_we = el_ok && item_ff.table_select;
            rw_we = el_ok && item_ff.table_select;
         end
         ST_EL_READ: begin
            ec_raddr = ent_addr(item_ff.element_index, 32'(item_ff.dim_index));
            rc_raddr = rel_addr(item_ff.element_index, 32'(item_ff.dim_index));
         end
         default: begin
         end
      endcase
   end

   // register next values
   always_comb begin
      item_in = item_ff; kind_in = kind_ff;
      lr_in = lr_ff; margin_in = margin_ff; mode_in = mode_ff;
      pass_in = pass_ff; i_in = i_ff; u_in = u_ff; v_in = v_ff;
      t_in = t_ff; h_in = h_ff; j_in = j_ff; r_in = r_ff;
      prod_in = mult_p;
      accp_in = accp_ff; accn_in = accn_ff; sp_in = sp_ff; sn_in = sn_ff;
      ss_in = ss_ff; sq_rem_in = sq_rem_ff; sq_res_in = sq_res_ff; sq_bit_in = sq_bit_ff;
      len_in = len_ff; neg_in = neg_ff;
      div_rem_in = div_rem_ff; div_lo_in = div_lo_ff; dc_in = dc_ff;
      cm_cnt_in = cm_cnt_ff; cm_prev_in = cm_prev_ff;
      cm_we_e_in = cm_we_e_ff; cm_we_r_in = cm_we_r_ff;
      total_in = total_ff; hinge_in = hinge_ff; applied_in = applied_ff; readv_in = readv_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_LEARNING_RATE: lr_in = csr_write_data;
            CSR_MARGIN:        margin_in = csr_write_data;
            CSR_DISTANCE_MODE: mode_in = csr_write_data[0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               item_in = req_item;
               kind_in = req_tuser;
               pass_in = 1'b0;
               i_in = '0;
               accp_in = '0;
               accn_in = '0;
               hinge_in = '0;
               applied_in = 1'b0;
               readv_in = '0;
               cm_cnt_in = '0;
               cm_we_e_in = 1'b0;
               cm_we_r_in = 1'b0;
               if (req_tuser == KIND_CLEAR) begin
                  total_in = '0;
               end
            end
         end
         ST_DIST_RD_H: begin
            t_in = ec_rdata;
            r_in = rc_rdata;
         end
         ST_DIST_RD_J: h_in = ec_rdata;
         ST_DIST_POS:  j_in = ec_rdata;
         ST_DIST_NEG:  accp_in = accp_ff + (mode_ff ? AW'(dp_abs) : AW'(prod_u));
         ST_DIST_ACC: begin
            accn_in = accn_ff + (mode_ff ? AW'(dn_abs) : AW'(prod_u));
            i_in = i_ff + 1'b1;
            if (i_last) begin
               i_in = '0;
            end
         end
         ST_DIST_END: begin
            i_in = '0;
            if (viol) begin
               pass_in = 1'b1;
               applied_in = 1'b1;
               hinge_in = (|hinge_full[AW:32]) ? 32'hFFFF_FFFF : hinge_full[31:0];
               total_in = total_sum[48] ? 48'hFFFF_FFFF_FFFF : total_sum[47:0];
            end else begin
               v_in = 2'd0;
               ss_in = '0;
            end
         end
         ST_GRAD_SP:  j_in = ec_rdata;
         ST_GRAD_SN:  sp_in = round_step(prod_ff);
         ST_GRAD_SNR: begin
            sn_in = round_step(prod_ff);
            u_in = 3'd0;
         end
         ST_RMW_WR: begin
            u_in = u_ff + 3'd1;
            if (u_ff == 3'd5) begin
               i_in = i_ff + 1'b1;
               if (i_last) begin
                  i_in = '0;
                  v_in = 2'd0;
                  ss_in = '0;
               end
            end
         end
         ST_NS_ACC: begin
            ss_in = ss_ff + SW'(prod_u);
            i_in = i_ff + 1'b1;
            if (i_last) begin
               i_in = '0;
            end
         end
         ST_NS_CHK: begin
            sq_rem_in = ss_ff;
            sq_res_in = '0;
            sq_bit_in = SW'(1) << SQ_EXP;
            if (ss_ff <= SW'(32'h0100_0000)) begin
               v_in = v_ff + 2'd1;
               ss_in = '0;
            end
         end
         ST_SQRT: begin
            if (sq_ge) begin
               sq_rem_in = sq_rem_ff - sq_rpb;
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
            len_in = LW'(sq_res_in);
            i_in = '0;
         end
         ST_ND_LD: begin
            neg_in = vec_old[15];
            div_rem_in = LW'(nd_num[28:16]);
            div_lo_in = nd_num[15:0];
            dc_in = '0;
         end
         ST_ND_DIV: begin
            div_rem_in = div_ge ? LW'(div_trial - {1'b0, len_ff}) : LW'(div_trial);
            div_lo_in = {div_lo_ff[14:0], div_ge};
            dc_in = dc_ff + 4'd1;
         end
         ST_ND_WR: begin
            i_in = i_ff + 1'b1;
            if (i_last) begin
               i_in = '0;
               v_in = v_ff + 2'd1;
               ss_in = '0;
            end
         end
         ST_COMMIT: begin
            if (cm_cnt_ff != CW'(CDEPTH)) begin
               cm_we_e_in = (cm_cnt_ff < CW'(EDEPTH));
               cm_we_r_in = (cm_cnt_ff < CW'(RDEPTH));
               cm_prev_in = cm_cnt_ff;
               cm_cnt_in = cm_cnt_ff + 1'b1;
            end else begin
               cm_we_e_in = 1'b0;
               cm_we_r_in = 1'b0;
            end
         end
         ST_EL_CAP: begin
            readv_in = el_ok ? (item_ff.table_select ? rc_rdata : ec_rdata) : 16'd0;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {7'b0, total_ff, readv_ff, applied_ff, hinge_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lr_ff <= LR_RESET;
         margin_ff <= MARGIN_RESET;
         mode_ff <= 1'b0;
         total_ff <= '0;
         cm_we_e_ff <= 1'b0;
         cm_we_r_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         lr_ff <= lr_in;
         margin_ff <= margin_in;
         mode_ff <= mode_in;
         total_ff <= total_in;
         cm_we_e_ff <= cm_we_e_in;
         cm_we_r_ff <= cm_we_r_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in; kind_ff <= kind_in;
      pass_ff <= pass_in; i_ff <= i_in; u_ff <= u_in; v_ff <= v_in;
      t_ff <= t_in; h_ff <= h_in; j_ff <= j_in; r_ff <= r_in;
      prod_ff <= prod_in;
      accp_ff <= accp_in; accn_ff <= accn_in; sp_ff <= sp_in; sn_ff <= sn_in;
      ss_ff <= ss_in; sq_rem_ff <= sq_rem_in; sq_res_ff <= sq_res_in; sq_bit_ff <= sq_bit_in;
      len_ff <= len_in; neg_ff <= neg_in;
      div_rem_ff <= div_rem_in; div_lo_ff <= div_lo_in; dc_ff <= dc_in;
      cm_cnt_ff <= cm_cnt_in; cm_prev_ff <= cm_prev_in;
      hinge_ff <= hinge_in; applied_ff <= applied_in; readv_ff <= readv_in;
      rsp_data_ff <= rsp_data_in;
   end

   msgd_ram #(.WIDTH(16), .DEPTH(EDEPTH), .ADDR_WIDTH(EAW)) u_ent_committed (
      .clock(clock), .write_enable(ec_we), .write_address(ec_waddr),
      .write_data(ec_wdata), .read_address(ec_raddr), .read_data(ec_rdata)
   );

   msgd_ram #(.WIDTH(16), .DEPTH(EDEPTH), .ADDR_WIDTH(EAW)) u_ent_working (
      .clock(clock), .write_enable(ew_we), .write_address(ew_waddr),
      .write_data(ew_wdata), .read_address(ew_raddr), .read_data(ew_rdata)
   );

   msgd_ram #(.WIDTH(16), .DEPTH(RDEPTH), .ADDR_WIDTH(RAW)) u_rel_committed (
      .clock(clock), .write_enable(rc_we), .write_address(rc_waddr),
      .write_data(rc_wdata), .read_address(rc_raddr), .read_data(rc_rdata)
   );

   msgd_ram #(.WIDTH(16), .DEPTH(RDEPTH), .ADDR_WIDTH(RAW)) u_rel_working (
      .clock(clock), .write_enable(rw_we), .write_address(rw_waddr),
      .write_data(rw_wdata), .read_address(rw_raddr), .read_data(rw_rdata)
   );

endmodule

[src/msgd_ram.sv]
module msgd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  write_enable,
   input  logic [ADDR_WIDTH-1:0] write_address,
   input  logic [WIDTH-1:0]      write_data,
   input  logic [ADDR_WIDTH-1:0] read_address,
   output logic [WIDTH-1:0]      read_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
      read_data <= mem[read_address];
   end

endmodule

[tb/margin_embedding_sgd_step_test.sv]
`timescale 1ns / 100ps

module margin_embedding_sgd_step_test;
   import msgd_pkg::*;

   localparam int N_ENT = 4096;
   localparam int N_REL = 256;
   localparam int D = 64;
   localparam longint TOTAL_MAX = 64'hFFFF_FFFF_FFFF;
   localparam longint CYCLE_LIMIT = 60_000_000;

   typedef struct {
      logic [2:0] kind;
      item_type   body;
   } req_type;

   typedef struct {
      logic [31:0] hinge;
      logic        applied;
      logic [15:0] readv;
      logic [47:0] total;
   } score_type;

   typedef struct {
      logic sel;
      int   row;
      int   dim;
   } cell_type;

   logic                 clock;
   logic                 reset;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [REQ_WIDTH-1:0] req_tdata;
   logic [2:0]           req_tuser;
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [RSP_WIDTH-1:0] rsp_tdata;
   logic                 csr_write_enable;
   logic [1:0]           csr_index;
   logic [15:0]          csr_write_data;

   margin_embedding_sgd_step uut (.*);

   // predictor state
   shortint ent_committed [N_ENT*D];
   shortint ent_working   [N_ENT*D];
   shortint rel_committed [N_REL*D];
   shortint rel_working   [N_REL*D];
   longint  loss_total;
   longint  lr_now, margin_now;
   bit      l1_mode;

   req_type   pending[$];
   score_type expected_scores[$];
   cell_type  written_cells[$];

   int     req_issued, req_accepts, req_gap, req_quiet;
   int     rsp_count, rsp_seen, rsp_stall, rsp_quiet;
   longint cycles;
   int     errors;
   int     n_train, n_violations, n_reads, n_writes, n_commits;
   req_type   next_req;
   score_type got;

   int ent_pool[8] = '{0, 4095, 1, 2, 100, 2047, 3000, 7};
   int rel_pool[4] = '{0, 255, 3, 17};

   function automatic shortint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return shortint'(v);
   endfunction

   function automatic longint div_round(longint num, longint den);
      longint mag, q;
      mag = num < 0 ? -num : num;
      q = (mag + den / 2) / den;
      return num < 0 ? -q : q;
   endfunction

   function automatic longint isqrt(longint v);
      longint res, b;
      res = 0;
      b = 64'sd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint diff_at(int h, int t, int r, int i);
      return longint'(ent_committed[t*D+i]) - ent_committed[h*D+i] - rel_committed[r*D+i];
   endfunction

   function automatic longint pair_distance(int h, int t, int r);
      longint acc, d;
      acc = 0;
      for (int i = 0; i < D; i++) begin
         d = diff_at(h, t, r, i);
         acc += l1_mode ? (d < 0 ? -d : d) : d * d;
      end
      return l1_mode ? acc : acc >> 12;
   endfunction

   function automatic longint grad_step(int h, int t, int r, int i);
      longint d, x;
      d = diff_at(h, t, r, i);
      x = l1_mode ? (d > 0 ? GRAD_ONE : -GRAD_ONE) : 2 * d;
      return div_round(lr_now * x, 65536);
   endfunction

   task automatic renorm(input bit sel, input int row);
      shortint v[D];
      longint  s, len;
      s = 0;
      for (int i = 0; i < D; i++) begin
         v[i] = sel ? rel_working[row*D+i] : ent_working[row*D+i];
         s += longint'(v[i]) * v[i];
      end
      if (s <= (64'sd1 << 24)) return;
      len = isqrt(s);
      for (int i = 0; i < D; i++) begin
         v[i] = sat16(div_round(longint'(v[i]) * 4096, len));
         if (sel) rel_working[row*D+i] = v[i];
         else ent_working[row*D+i] = v[i];
      end
   endtask

   task automatic predict(input logic [2:0] kind, input item_type it, output score_type res);
      int     h, t, r, j, nh, nt, idx;
      longint dp, dn, v, sp, sn;
      res.hinge = 0;
      res.applied = 0;
      res.readv = 0;
      case (kind)
         KIND_TRAIN: begin
            n_train++;
            h = it.head;
            t = it.tail;
            r = it.relation;
            j = it.corrupt_entity;
            nh = it.corrupt_head ? j : h;
            nt = it.corrupt_head ? t : j;
            dp = pair_distance(h, t, r);
            dn = pair_distance(nh, nt, r);
            if (dp + margin_now > dn) begin
               n_violations++;
               v = margin_now + dp - dn;
               res.hinge = v > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : v[31:0];
               v = res.hinge;
               loss_total = (TOTAL_MAX - loss_total < v) ? TOTAL_MAX : loss_total + v;
               res.applied = 1;
               for (int i = 0; i < D; i++) begin
                  sp = grad_step(h, t, r, i);
                  sn = grad_step(nh, nt, r, i);
                  rel_working[r*D+i] = sat16(rel_working[r*D+i] + sp);
                  ent_working[h*D+i] = sat16(ent_working[h*D+i] + sp);
                  ent_working[t*D+i] = sat16(ent_working[t*D+i] - sp);
                  rel_working[r*D+i] = sat16(rel_working[r*D+i] - sn);
                  ent_working[nh*D+i] = sat16(ent_working[nh*D+i] - sn);
                  ent_working[nt*D+i] = sat16(ent_working[nt*D+i] + sn);
               end
            end
            renorm(1, r);
            renorm(0, h);
            renorm(0, t);
            renorm(0, j);
         end
         KIND_COMMIT: begin
            n_commits++;
            ent_committed = ent_working;
            rel_committed = rel_working;
         end
         KIND_WRITE, KIND_READ: begin
            idx = it.element_index * D + it.dim_index;
            if (it.element_index < (it.table_select ? N_REL : N_ENT)) begin
               if (kind == KIND_WRITE) begin
                  n_writes++;
                  if (it.table_select) begin
                     rel_committed[idx] = shortint'(it.write_value);
                     rel_working[idx] = shortint'(it.write_value);
                  end else begin
                     ent_committed[idx] = shortint'(it.write_value);
                     ent_working[idx] = shortint'(it.write_value);
                  end
               end else begin
                  n_reads++;
                  res.readv = it.table_select ? rel_committed[idx] : ent_committed[idx];
               end
            end
         end
         KIND_CLEAR: loss_total = 0;
         default: ;
      endcase
      res.total = loss_total[47:0];
   endtask

   function automatic int draw_wait(ref int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) quiet = $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   task automatic check_field(input string name, input longint exp, input longint act);
      if (exp != act) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp, act);
      end
   endtask

   // clock, cycle limit
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (req_tvalid && req_accepts != req_issued) begin
      end else if (req_gap > 0) begin
         req_tvalid <= 0;
         req_gap <= req_gap - 1;
      end else if (pending.size() > 0) begin
         next_req = pending.pop_front();
         req_tdata <= next_req.body;
         req_tuser <= next_req.kind;
         req_tvalid <= 1;
         req_issued <= req_issued + 1;
         req_gap <= draw_wait(req_quiet);
      end else begin
         req_tvalid <= 0;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_seen != rsp_count) begin
            rsp_seen = rsp_count;
            rsp_stall = draw_wait(rsp_quiet);
         end
         if (rsp_stall > 0) begin
            rsp_tready <= 0;
            rsp_stall--;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict(req_tuser, item_type'(req_tdata), got);
            expected_scores.push_back(got);
            req_accepts <= req_accepts + 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            rsp_count <= rsp_count + 1;
            if (expected_scores.size() == 0) begin
               errors++;
               $display("%0t: unexpected item, got %h", $time, rsp_tdata);
            end else begin
               got = expected_scores.pop_front();
               check_field("hinge_loss", got.hinge, rsp_tdata[31:0]);
               check_field("update_applied", got.applied, rsp_tdata[32]);
               check_field("read_value", got.readv, rsp_tdata[48:33]);
               check_field("total_loss", got.total, rsp_tdata[96:49]);
            end
         end
      end
   end

   // stimulus
   task automatic push_item(input logic [2:0] kind, input item_type it);
      req_type q;
      q.kind = kind;
      q.body = it;
      pending.push_back(q);
   endtask

   task automatic push_train(input int h, input int t, input int r, input int j, input bit ch);
      item_type it;
      it = item_type'($urandom_range(0, 32'hFFFF_FFFF));
      it.head = h;
      it.tail = t;
      it.relation = r;
      it.corrupt_entity = j;
      it.corrupt_head = ch;
      push_item(KIND_TRAIN, it);
   endtask

   task automatic push_cell(input logic [2:0] kind, input bit sel, input int row,
                            input int dim, input logic [15:0] val);
      item_type it;
      cell_type c;
      it = '0;
      it.head = $urandom;
      it.relation = $urandom;
      it.table_select = sel;
      it.element_index = row;
      it.dim_index = dim;
      it.write_value = val;
      push_item(kind, it);
      if (kind == KIND_WRITE && row < (sel ? N_REL : N_ENT)) begin
         c.sel = sel;
         c.row = row;
         c.dim = dim;
         written_cells.push_back(c);
      end
   endtask

   task automatic push_plain(input logic [2:0] kind);
      push_item(kind, item_type'({$urandom, $urandom, $urandom}));
   endtask

   task automatic push_random(input int n);
      int       pick, row;
      bit       sel;
      cell_type c;
      repeat (n) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            push_train(ent_pool[$urandom_range(0, 7)], ent_pool[$urandom_range(0, 7)],
                       rel_pool[$urandom_range(0, 3)], ent_pool[$urandom_range(0, 7)],
                       $urandom_range(0, 1));
         end else if (pick < 75) begin
            sel = $urandom_range(0, 1);
            if ($urandom_range(0, 1)) begin
               row = sel ? rel_pool[$urandom_range(0, 3)] : ent_pool[$urandom_range(0, 7)];
               push_cell(KIND_WRITE, sel, row, $urandom_range(0, 63),
                         $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096) - 2048);
            end else begin
               push_cell(KIND_WRITE, sel, $urandom_range(0, 4095), $urandom_range(0, 63),
                         $urandom);
            end
         end else if (pick < 92) begin
            if ($urandom_range(0, 9) == 0) begin
               push_cell(KIND_READ, 1, $urandom_range(N_REL, 4095), $urandom_range(0, 63),
                         $urandom);
            end else begin
               c = written_cells[$urandom_range(0, written_cells.size() - 1)];
               push_cell(KIND_READ, c.sel, c.row, c.dim, $urandom);
            end
         end else if (pick < 96) begin
            push_plain(KIND_CLEAR);
         end else begin
            push_plain(3'($urandom_range(5, 7)));
         end
      end
   endtask

   task automatic drain();
      while (pending.size() > 0 || req_accepts != req_issued || expected_scores.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 0;
      case (idx)
         CSR_LEARNING_RATE: lr_now = val;
         CSR_MARGIN:        margin_now = val;
         default:           l1_mode = val[0];
      endcase
   endtask

   task automatic configure(input logic [15:0] lr, input logic [15:0] mg, input bit mode);
      set_reg(CSR_LEARNING_RATE, lr);
      set_reg(CSR_MARGIN, mg);
      set_reg(CSR_DISTANCE_MODE, mode);
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 0;
      csr_write_enable = 0;
      csr_index = '0;
      csr_write_data = '0;
      lr_now = LR_RESET;
      margin_now = MARGIN_RESET;
      l1_mode = 0;
      loss_total = 0;
      repeat (12) @(posedge clock);
      reset <= 0;

      // every vector that training touches is fully written first
      foreach (ent_pool[k])
         for (int i = 0; i < D; i++)
            push_cell(KIND_WRITE, 0, ent_pool[k], i, $urandom_range(0, 2048) - 1024);
      foreach (rel_pool[k])
         for (int i = 0; i < D; i++)
            push_cell(KIND_WRITE, 1, rel_pool[k], i, $urandom_range(0, 2048) - 1024);

      push_cell(KIND_READ, 0, 0, 0, 0);
      push_cell(KIND_READ, 1, 255, 63, 16'hFFFF);
      push_cell(KIND_READ, 1, 4095, 5, 0);
      push_cell(KIND_WRITE, 1, 300, 7, 16'h8000);
      push_cell(KIND_WRITE, 0, 4095, 63, 16'h7FFF);
      push_cell(KIND_WRITE, 0, 4095, 0, 16'h8000);
      push_cell(KIND_READ, 0, 4095, 63, 0);
      push_cell(KIND_READ, 0, 4095, 0, 0);
      push_plain(3'd5);
      push_plain(3'd6);
      push_plain(3'd7);
      push_train(0, 4095, 0, 1, 1);
      push_train(4095, 0, 255, 4095, 0);
      push_train(2, 2, 3, 2, 1);
      push_train(7, 100, 17, 7, 1);
      push_train(2047, 3000, 3, 3000, 0);
      push_plain(KIND_COMMIT);
      push_cell(KIND_READ, 0, 4095, 63, 0);
      push_cell(KIND_READ, 1, 3, 10, 0);
      push_train(1, 2, 0, 4095, 0);
      push_plain(KIND_CLEAR);
      push_train(100, 7, 255, 0, 1);
      push_random(375);
      drain();

      configure(16'hFFFF, 16'hFFFF, 1);
      push_random(180);
      push_plain(KIND_COMMIT);
      push_random(195);
      drain();

      configure(16'h0000, 16'h0000, 0);
      push_random(375);
      drain();

      configure($urandom, $urandom_range(0, 8192), 1);
      push_random(200);
      push_plain(KIND_COMMIT);
      push_random(175);
      drain();

      $display("%0d train items, %0d with margin violated; %0d commits",
               n_train, n_violations, n_commits);
      $display("%0d element writes, %0d reads; %0d cycles", n_writes, n_reads, cycles);
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
